/* rtl/hj_pkg.sv */
// Shared constants for the homography Jacobian block.
`timescale 1ns / 1ps
package hj_pkg;
  localparam int LANES     = 4;
  localparam int LOC_FRAC  = 8;
  localparam int SCALE_SH  = 24;
  localparam int QBITS     = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 32;
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic ready;
  } hj_link_t;
endpackage

/* rtl/hj_queue.sv */
// Small register FIFO between front and back pipelines.
`timescale 1ns / 1ps
module hj_queue import hj_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

/* rtl/hj_front.sv */
// Front pipeline: weight, degenerate check, numerators and w squared.
`timescale 1ns / 1ps
module hj_front import hj_pkg::*; #(
  parameter int CW = 32,
  parameter int LW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_W-1:0]     weight_floor,
  input  logic                 push,
  output logic                 full,
  input  logic signed [CW-1:0] h00,
  input  logic signed [CW-1:0] h01,
  input  logic signed [CW-1:0] h02,
  input  logic signed [CW-1:0] h10,
  input  logic signed [CW-1:0] h11,
  input  logic signed [CW-1:0] h12,
  input  logic signed [CW-1:0] h20,
  input  logic signed [CW-1:0] h21,
  input  logic signed [CW-1:0] h22,
  input  logic signed [LW-1:0] loc_x,
  input  logic signed [LW-1:0] loc_y,
  output hj_link_t             link,
  input  logic                 link_ready,
  output logic [LANES*(2*CW+LW+3)+2*(CW+LW+2):0] out_data
);
  localparam int PW = CW + LW;
  localparam int SW = PW + 1;
  localparam int WW = PW + 2;
  localparam int AL = (SW + 1) / 2;
  localparam int AH = SW - AL;
  localparam int WL = WW / 2;
  localparam int WH = WW - WL;
  localparam int MH = CW + AH;
  localparam int ML = CW + AL + 1;
  localparam int NW = CW + SW + 1;
  localparam int LANE_W = NW + 1;

  logic en;
  logic va, vb, vc, vd, ve, vf;

  // stage A
  logic signed [PW-1:0] m20x, m21y, m01y, m00x, m11y, m10x;
  logic signed [CW-1:0] a_h00, a_h01, a_h10, a_h11, a_h20, a_h21, a_h02, a_h12, a_h22;
  // stage B
  logic signed [SW-1:0] ay, ax, b0, b1, b2, b3;
  logic signed [WW-1:0] w;
  logic signed [CW-1:0] b_h00, b_h01, b_h10, b_h11, b_h20, b_h21;
  logic signed [SW-1:0] h22s, h02s, h12s;
  logic signed [WW-1:0] h22w;
  // stage C
  logic signed [CW-1:0] p_sel [LANES];
  logic signed [CW-1:0] s_sel [LANES];
  logic signed [SW-1:0] a_sel [LANES];
  logic signed [SW-1:0] b_sel [LANES];
  logic signed [MH-1:0] pa_hi [LANES];
  logic signed [MH-1:0] sb_hi [LANES];
  logic signed [ML-1:0] pa_lo [LANES];
  logic signed [ML-1:0] sb_lo [LANES];
  logic [WW-1:0]        wabs;
  // stage D
  logic signed [MH:0]   hd [LANES];
  logic signed [ML:0]   ld [LANES];
  logic [2*WH-1:0]      hh;
  logic [WH+WL-1:0]     hl;
  logic [2*WL-1:0]      ll;
  logic                 solv_d;
  // stage E
  logic signed [NW-1:0] num [LANES];
  logic [2*WW-1:0]      w2_e;
  logic                 solv_e;
  // stage F
  logic [NW-1:0]        nabs [LANES];
  logic                 nneg [LANES];
  logic [2*WW-1:0]      w2_f;
  logic                 solv_f;

  assign en         = !vf || link_ready;
  assign full       = !en;
  assign link.valid = vf;
  assign link.ready = en;

  assign h22s = {{(SW-CW-LOC_FRAC){a_h22[CW-1]}}, a_h22, {LOC_FRAC{1'b0}}};
  assign h02s = {{(SW-CW-LOC_FRAC){a_h02[CW-1]}}, a_h02, {LOC_FRAC{1'b0}}};
  assign h12s = {{(SW-CW-LOC_FRAC){a_h12[CW-1]}}, a_h12, {LOC_FRAC{1'b0}}};
  assign h22w = {{(WW-CW-LOC_FRAC){a_h22[CW-1]}}, a_h22, {LOC_FRAC{1'b0}}};

  always_comb begin
    p_sel[0] = b_h00; a_sel[0] = ay; s_sel[0] = b_h20; b_sel[0] = b0;
    p_sel[1] = b_h01; a_sel[1] = ax; s_sel[1] = b_h21; b_sel[1] = b1;
    p_sel[2] = b_h10; a_sel[2] = ay; s_sel[2] = b_h20; b_sel[2] = b2;
    p_sel[3] = b_h11; a_sel[3] = ax; s_sel[3] = b_h21; b_sel[3] = b3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else if (en) begin
      va <= push;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A: coefficient by location products
      m20x  <= h20 * loc_x;
      m21y  <= h21 * loc_y;
      m01y  <= h01 * loc_y;
      m00x  <= h00 * loc_x;
      m11y  <= h11 * loc_y;
      m10x  <= h10 * loc_x;
      a_h00 <= h00;
      a_h01 <= h01;
      a_h10 <= h10;
      a_h11 <= h11;
      a_h20 <= h20;
      a_h21 <= h21;
      a_h02 <= h02;
      a_h12 <= h12;
      a_h22 <= h22;
      // B: affine sums, Q.32
      ay    <= SW'(m21y) + h22s;
      ax    <= SW'(m20x) + h22s;
      b0    <= SW'(m01y) + h02s;
      b1    <= SW'(m00x) + h02s;
      b2    <= SW'(m11y) + h12s;
      b3    <= SW'(m10x) + h12s;
      w     <= WW'(m20x) + WW'(m21y) + h22w;
      b_h00 <= a_h00;
      b_h01 <= a_h01;
      b_h10 <= a_h10;
      b_h11 <= a_h11;
      b_h20 <= a_h20;
      b_h21 <= a_h21;
      // C: split products
      for (int i = 0; i < LANES; i++) begin
        pa_hi[i] <= p_sel[i] * $signed(a_sel[i][SW-1:AL]);
        sb_hi[i] <= s_sel[i] * $signed(b_sel[i][SW-1:AL]);
        pa_lo[i] <= p_sel[i] * $signed({1'b0, a_sel[i][AL-1:0]});
        sb_lo[i] <= s_sel[i] * $signed({1'b0, b_sel[i][AL-1:0]});
      end
      wabs <= w[WW-1] ? WW'(-w) : WW'(w);
      // D
      for (int i = 0; i < LANES; i++) begin
        hd[i] <= (MH+1)'(pa_hi[i]) - (MH+1)'(sb_hi[i]);
        ld[i] <= (ML+1)'(pa_lo[i]) - (ML+1)'(sb_lo[i]);
      end
      hh     <= wabs[WW-1:WL] * wabs[WW-1:WL];
      hl     <= wabs[WW-1:WL] * wabs[WL-1:0];
      ll     <= wabs[WL-1:0] * wabs[WL-1:0];
      solv_d <= (wabs != '0) && ({{CFG_W{1'b0}}, wabs} >= {{WW{1'b0}}, weight_floor});
      // E: numerators Q.56, w squared Q.64
      for (int i = 0; i < LANES; i++) begin
        num[i] <= (NW'(hd[i]) <<< AL) + NW'(ld[i]);
      end
      w2_e   <= {hh, ll} + ((2*WW)'(hl) << (WL + 1));
      solv_e <= solv_d;
      // F: sign and magnitude
      for (int i = 0; i < LANES; i++) begin
        nneg[i] <= num[i][NW-1];
        nabs[i] <= num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
      end
      w2_f   <= w2_e;
      solv_f <= solv_e;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_data[i*LANE_W +: LANE_W] = {nneg[i], nabs[i]};
    end
    out_data[LANES*LANE_W +: 2*WW] = w2_f;
    out_data[LANES*LANE_W + 2*WW]  = solv_f;
  end
endmodule

/* rtl/hj_back.sv */
// Back pipeline: one quotient bit per stage, rounding and saturation.
`timescale 1ns / 1ps
module hj_back import hj_pkg::*; #(
  parameter int CW = 32,
  parameter int LW = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_pop,
  input  logic [LANES*(2*CW+LW+3)+2*(CW+LW+2):0] in_data,
  output logic empty,
  input  logic pop,
  output logic signed [OUT_W-1:0] du_dx,
  output logic signed [OUT_W-1:0] du_dy,
  output logic signed [OUT_W-1:0] dv_dx,
  output logic signed [OUT_W-1:0] dv_dy,
  output logic solvable
);
  localparam int WW = CW + LW + 2;
  localparam int NW = 2 * CW + LW + 2;
  localparam int LANE_W = NW + 1;
  localparam int RA = NW + SCALE_SH;
  localparam int RB = 2 * WW + QBITS + 1;
  localparam int RW = (RA > RB) ? RA : RB;
  localparam int NS = QBITS + 1;

  logic en;
  logic v_out;

  logic          v    [NS];
  logic [RW-1:0] rem  [NS][LANES];
  logic [QBITS-1:0] quo [NS][LANES];
  logic          neg  [NS][LANES];
  logic          sat  [NS][LANES];
  logic [RW-1:0] dvs  [NS];
  logic          solv [NS];

  logic [NW-1:0]    in_abs [LANES];
  logic             in_neg [LANES];
  logic [2*WW-1:0]  in_w2;
  logic [OUT_W-1:0] res [LANES];

  assign en     = !v_out || pop;
  assign in_pop = en && in_valid;
  assign empty  = !v_out;
  assign in_w2  = in_data[LANES*LANE_W +: 2*WW];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      {in_neg[i], in_abs[i]} = in_data[i*LANE_W +: LANE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // setup: dividend |num| << 24, overflow when |num| >= w2 << 8
  always_ff @(posedge clk) begin
    if (en) begin
      dvs[0]  <= RW'(in_w2);
      solv[0] <= in_data[LANES*LANE_W + 2*WW];
      for (int i = 0; i < LANES; i++) begin
        rem[0][i] <= RW'(in_abs[i]) << SCALE_SH;
        quo[0][i] <= '0;
        neg[0][i] <= in_neg[i];
        sat[0][i] <= RW'(in_abs[i]) >= (RW'(in_w2) << LOC_FRAC);
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_div
    localparam int BIT = QBITS - s;
    logic [RW-1:0] dsh;
    assign dsh = dvs[s-1] << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[s]  <= dvs[s-1];
        solv[s] <= solv[s-1];
        for (int i = 0; i < LANES; i++) begin
          neg[s][i] <= neg[s-1][i];
          sat[s][i] <= sat[s-1][i];
          if (rem[s-1][i] >= dsh) begin
            rem[s][i] <= rem[s-1][i] - dsh;
            quo[s][i] <= quo[s-1][i] | (QBITS'(1) << BIT);
          end else begin
            rem[s][i] <= rem[s-1][i];
            quo[s][i] <= quo[s-1][i];
          end
        end
      end
    end
  end

  // round half away from zero on the magnitude, then clamp; zero when not solvable
  always_comb begin
    logic [QBITS:0] mag;
    logic           rnd;
    for (int i = 0; i < LANES; i++) begin
      rnd = {rem[NS-1][i], 1'b0} >= {1'b0, dvs[NS-1]};
      mag = {1'b0, quo[NS-1][i]} + (QBITS+1)'(rnd);
      if (!solv[NS-1]) begin
        res[i] = '0;
      end else if (sat[NS-1][i]) begin
        res[i] = neg[NS-1][i] ? OUT_MIN : OUT_MAX;
      end else if (neg[NS-1][i]) begin
        res[i] = (mag > (QBITS+1)'(OUT_MIN)) ? OUT_MIN : OUT_W'(-mag);
      end else begin
        res[i] = (mag > (QBITS+1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du_dx    <= res[0];
      du_dy    <= res[1];
      dv_dx    <= res[2];
      dv_dy    <= res[3];
      solvable <= solv[NS-1];
    end
  end
endmodule

/* rtl/homography_jacobian.sv */
// Top level of the homography Jacobian block.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  config  | cfg_we             | cfg_wdata (weight_floor)
//  input   | push / full        | h00..h22, loc_x, loc_y
//  result  | pop / empty        | du_dx, du_dy, dv_dx, dv_dy, solvable
//
// One item per cycle sustained while results are popped. Items pass through
// 6 front stages, the queue, a divider setup stage, 32 divider stages (one
// quotient bit each) and the output register.
// Reset clears all valid flags and sets weight_floor to 1.
// Front stalls only when the queue is full; back stalls only when the
// output register holds an item that is not popped.
`timescale 1ns / 1ps
module homography_jacobian import hj_pkg::*; #(
  parameter int COEF_WIDTH = 32,
  parameter int LOC_WIDTH  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COEF_WIDTH-1:0] h00,
  input  logic signed [COEF_WIDTH-1:0] h01,
  input  logic signed [COEF_WIDTH-1:0] h02,
  input  logic signed [COEF_WIDTH-1:0] h10,
  input  logic signed [COEF_WIDTH-1:0] h11,
  input  logic signed [COEF_WIDTH-1:0] h12,
  input  logic signed [COEF_WIDTH-1:0] h20,
  input  logic signed [COEF_WIDTH-1:0] h21,
  input  logic signed [COEF_WIDTH-1:0] h22,
  input  logic signed [LOC_WIDTH-1:0]  loc_x,
  input  logic signed [LOC_WIDTH-1:0]  loc_y,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [OUT_W-1:0]      du_dx,
  output logic signed [OUT_W-1:0]      du_dy,
  output logic signed [OUT_W-1:0]      dv_dx,
  output logic signed [OUT_W-1:0]      dv_dy,
  output logic                         solvable
);
  localparam int QW = LANES * (2 * COEF_WIDTH + LOC_WIDTH + 3)
                    + 2 * (COEF_WIDTH + LOC_WIDTH + 2) + 1;
  localparam int QDEPTH = 4;

  logic [CFG_W-1:0] weight_floor;
  hj_link_t         f_link;
  logic [QW-1:0]    f_data;
  logic [QW-1:0]    q_data;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_floor <= CFG_W'(1);
    end else if (cfg_we) begin
      weight_floor <= cfg_wdata;
    end
  end

  hj_front #(
    .CW(COEF_WIDTH),
    .LW(LOC_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .weight_floor (weight_floor),
    .push         (push),
    .full         (full),
    .h00          (h00),
    .h01          (h01),
    .h02          (h02),
    .h10          (h10),
    .h11          (h11),
    .h12          (h12),
    .h20          (h20),
    .h21          (h21),
    .h22          (h22),
    .loc_x        (loc_x),
    .loc_y        (loc_y),
    .link         (f_link),
    .link_ready   (!q_full),
    .out_data     (f_data)
  );

  hj_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_link.valid),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  hj_back #(
    .CW(COEF_WIDTH),
    .LW(LOC_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_pop   (q_pop),
    .in_data  (q_data),
    .empty    (empty),
    .pop      (pop),
    .du_dx    (du_dx),
    .du_dy    (du_dy),
    .dv_dx    (dv_dx),
    .dv_dy    (dv_dy),
    .solvable (solvable)
  );
endmodule
